// File: rtl/core/imsu_pkg.sv
package imsu_pkg;

    localparam int SIDE       = 64;
    localparam int DEPTH      = SIDE * SIDE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = 6;
    localparam int DRAW_W     = 17;
    localparam int THR_W      = 17;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int K_W        = 4;
    localparam int TOT_W      = 15;
    localparam int OUT_TOT_W  = 14;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;

    localparam logic [TOT_W-1:0] MAG_RESET  = TOT_W'(SIDE * SIDE);
    localparam logic [TOT_W-1:0] BOND_RESET = TOT_W'(2 * SIDE * (SIDE - 1));
    localparam logic [THR_W-1:0] THR_RESET  = THR_W'(100000);

    // coupling modes
    localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_K1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_K2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_K3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_K4   = 3'd4;

    // command codes
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_TRIAL = 1'b1;

    // grid read selectors
    localparam logic [2:0] SEL_SITE  = 3'd0;
    localparam logic [2:0] SEL_UP    = 3'd1;
    localparam logic [2:0] SEL_DOWN  = 3'd2;
    localparam logic [2:0] SEL_LEFT  = 3'd3;
    localparam logic [2:0] SEL_RIGHT = 3'd4;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic [2:0]        rd_sel;
        logic              exec;
        logic              clr_en;
        logic [ADDR_W-1:0] clr_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/imsu_ctrl.sv
module imsu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  imsu_pkg::dp_status_t status,
    output imsu_pkg::dp_cmd_t    cmd
);
    import imsu_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        nb_cnt_reg, nb_cnt_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            nb_cnt_reg  <= '0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            nb_cnt_reg  <= nb_cnt_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        nb_cnt_next  = nb_cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd          = '0;
        cmd.clr_addr = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = SEL_SITE;
                    nb_cnt_next = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_UP + {1'b0, nb_cnt_reg};
                nb_cnt_next = nb_cnt_reg + 1'b1;
                if (nb_cnt_reg == 2'd3) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/imsu_datapath.sv
module imsu_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  imsu_pkg::dp_cmd_t                cmd,
    output imsu_pkg::dp_status_t             status,
    input  logic                             in_cmd,
    input  logic [imsu_pkg::IDX_W-1:0]       in_row,
    input  logic [imsu_pkg::IDX_W-1:0]       in_col,
    input  logic                             in_spin,
    input  logic [imsu_pkg::DRAW_W-1:0]      in_draw,
    input  logic                             cfg_we,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imsu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_accepted,
    output logic                             out_spin_now,
    output logic signed [imsu_pkg::K_W-1:0]  out_energy_units,
    output logic signed [imsu_pkg::OUT_TOT_W-1:0] out_magnetization,
    output logic signed [imsu_pkg::OUT_TOT_W-1:0] out_bond_sum
);
    import imsu_pkg::*;

    // configuration
    logic [MODE_W-1:0] mode_reg;
    logic [THR_W-1:0]  thr1_reg, thr2_reg, thr3_reg, thr4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_POS;
            thr1_reg <= THR_RESET;
            thr2_reg <= THR_RESET;
            thr3_reg <= THR_RESET;
            thr4_reg <= THR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COUPLING: mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_THR_K1:   thr1_reg <= cfg_wdata[THR_W-1:0];
                REG_THR_K2:   thr2_reg <= cfg_wdata[THR_W-1:0];
                REG_THR_K3:   thr3_reg <= cfg_wdata[THR_W-1:0];
                REG_THR_K4:   thr4_reg <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latched item
    logic              cmd_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic              spin_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic [ADDR_W-1:0] site_addr_reg;
    logic [ADDR_W-1:0] in_addr;

    assign in_addr = ADDR_W'(in_row) * ADDR_W'(SIDE) + ADDR_W'(in_col);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg       <= in_cmd;
            row_reg       <= in_row;
            col_reg       <= in_col;
            spin_reg      <= in_spin;
            draw_reg      <= in_draw;
            site_addr_reg <= in_addr;
        end
    end

    logic off_grid;
    logic up_ok, down_ok, left_ok, right_ok;

    assign off_grid = ({1'b0, row_reg} >= (IDX_W + 1)'(SIDE))
                   || ({1'b0, col_reg} >= (IDX_W + 1)'(SIDE));
    assign up_ok    = (row_reg != '0);
    assign down_ok  = (({1'b0, row_reg} + 1'b1) < (IDX_W + 1)'(SIDE));
    assign left_ok  = (col_reg != '0);
    assign right_ok = (({1'b0, col_reg} + 1'b1) < (IDX_W + 1)'(SIDE));

    // spin memory, bit set means spin -1
    logic              grid_mem [DEPTH];
    logic              rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] nb_addr;
    logic              new_bit;
    logic              change;

    always_comb begin
        case (cmd.rd_sel)
            SEL_UP:    nb_addr = site_addr_reg - ADDR_W'(SIDE);
            SEL_DOWN:  nb_addr = site_addr_reg + ADDR_W'(SIDE);
            SEL_LEFT:  nb_addr = site_addr_reg - 1'b1;
            SEL_RIGHT: nb_addr = site_addr_reg + 1'b1;
            default:   nb_addr = site_addr_reg;
        endcase
    end

    assign raddr = cmd.load ? in_addr : nb_addr;
    assign we    = cmd.clr_en | (cmd.exec & change);
    assign waddr = cmd.clr_en ? cmd.clr_addr : site_addr_reg;
    assign wdata = cmd.clr_en ? 1'b0 : new_bit;

    always_ff @(posedge aclk) begin
        if (we) begin
            grid_mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= grid_mem[raddr];
        end
    end

    // capture of read data, in the cycle after the read
    logic       cap_v_reg;
    logic [2:0] cap_sel_reg;
    logic       site_bit_reg;
    logic signed [K_W-1:0] nsum_reg;
    logic       cap_ok;
    logic signed [K_W-1:0] contrib;
    logic signed [K_W-1:0] nsum_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_v_reg <= 1'b0;
        end else begin
            cap_v_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        cap_sel_reg <= cmd.rd_sel;
    end

    always_comb begin
        case (cap_sel_reg)
            SEL_UP:    cap_ok = up_ok;
            SEL_DOWN:  cap_ok = down_ok;
            SEL_LEFT:  cap_ok = left_ok;
            SEL_RIGHT: cap_ok = right_ok;
            default:   cap_ok = 1'b0;
        endcase
    end

    assign contrib   = (cap_v_reg && cap_ok) ? (rdata_reg ? -4'sd1 : 4'sd1) : 4'sd0;
    assign nsum_full = nsum_reg + contrib;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nsum_reg <= '0;
        end else if (cap_v_reg) begin
            nsum_reg <= nsum_full;
        end
        if (cap_v_reg && cap_sel_reg == SEL_SITE) begin
            site_bit_reg <= rdata_reg;
        end
    end

    // decision
    logic                  coupled;
    logic                  negate;
    logic signed [K_W-1:0] k_val;
    logic                  k_pos;
    logic [THR_W-1:0]      thr_sel;
    logic                  accept;

    assign coupled = (mode_reg == MODE_POS) || (mode_reg == MODE_NEG);
    assign negate  = site_bit_reg ^ (mode_reg == MODE_NEG);
    assign k_val   = coupled ? (negate ? -nsum_full : nsum_full) : 4'sd0;
    assign k_pos   = !k_val[K_W-1] && (k_val != '0);

    always_comb begin
        case (k_val)
            4'sd1:   thr_sel = thr1_reg;
            4'sd2:   thr_sel = thr2_reg;
            4'sd3:   thr_sel = thr3_reg;
            default: thr_sel = thr4_reg;
        endcase
    end

    assign accept  = !k_pos || (draw_reg < thr_sel);
    assign new_bit = (cmd_reg == CMD_TRIAL) ? (site_bit_reg ^ accept) : spin_reg;
    assign change  = (new_bit != site_bit_reg) && !off_grid;

    // running totals
    logic signed [TOT_W-1:0] mag_reg, mag_next;
    logic signed [TOT_W-1:0] bond_reg, bond_next;
    logic signed [TOT_W-1:0] nsum2;

    assign nsum2 = TOT_W'(nsum_full) <<< 1;

    always_comb begin
        mag_next  = mag_reg;
        bond_next = bond_reg;
        if (change) begin
            mag_next  = site_bit_reg ? mag_reg + TOT_W'(2) : mag_reg - TOT_W'(2);
            bond_next = site_bit_reg ? bond_reg + nsum2 : bond_reg - nsum2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg  <= MAG_RESET;
            bond_reg <= BOND_RESET;
        end else if (cmd.exec) begin
            mag_reg  <= mag_next;
            bond_reg <= bond_next;
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (off_grid) begin
                out_accepted      <= 1'b0;
                out_spin_now      <= 1'b0;
                out_energy_units  <= '0;
                out_magnetization <= '0;
                out_bond_sum      <= '0;
            end else begin
                out_accepted      <= change;
                out_spin_now      <= new_bit;
                out_energy_units  <= k_val;
                out_magnetization <= mag_next[OUT_TOT_W-1:0];
                out_bond_sum      <= bond_next[OUT_TOT_W-1:0];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// File: rtl/core/ising_metropolis_spin_update_top.sv
// Metropolis single spin flip update on a 64 x 64 Ising grid, open boundaries.
// Input channel (s_): tuser is the command (set spin or run a trial), tdata
// carries row, column, spin to write and the random draw. Each item gives
// exactly one result item on the m_ channel: accepted flag, spin after the
// item, k before the item, running magnetization and running bond sum.
// Configuration: write cfg_we with cfg_index/cfg_wdata while no item is in
// flight; index 0 is the coupling mode, 1 to 4 the thresholds for k = 1..4.
// An item's result reaches the output register after five reads from the
// single-port spin memory (site at the accepting edge, then four neighbours,
// one per cycle) and a decision and write-back step. A new item is taken
// only once the previous one has gone into the output register.
// After reset the grid is swept back to all spins up, one entry a cycle,
// over all 4096 entries; s_tready stays low during the sweep. Totals and
// registers return to their reset values at once.
// A stalled receiver holds the result in the output register; the next item
// is still taken and processed, and waits in its last cycle until the
// output register is free.
module ising_metropolis_spin_update_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [imsu_pkg::S_DATA_W-1:0]       s_tdata,  // row, col, spin_value, random_draw
    input  logic                                s_tuser,  // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [imsu_pkg::M_DATA_W-1:0]       m_tdata,  // accepted, spin_now, energy_units,
                                                          // magnetization, bond_sum
    input  logic                                cfg_we,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imsu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import imsu_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    logic                         accepted;
    logic                         spin_now;
    logic signed [K_W-1:0]        energy_units;
    logic signed [OUT_TOT_W-1:0]  magnetization;
    logic signed [OUT_TOT_W-1:0]  bond_sum;

    imsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    imsu_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (dp_cmd),
        .status            (dp_status),
        .in_cmd            (s_tuser),
        .in_row            (s_tdata[5:0]),
        .in_col            (s_tdata[11:6]),
        .in_spin           (s_tdata[12]),
        .in_draw           (s_tdata[29:13]),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_accepted      (accepted),
        .out_spin_now      (spin_now),
        .out_energy_units  (energy_units),
        .out_magnetization (magnetization),
        .out_bond_sum      (bond_sum)
    );

    assign m_tdata = {6'd0, bond_sum, magnetization, energy_units, spin_now, accepted};

endmodule
